// ===== rtl/core/pcgr_pkg.sv =====
// shared types, register indexes and helper functions of the probabilistic clock gate router
// no dependencies; used by the top level in rtl/core and by the dv testbench files
package pcgr_pkg;

	localparam int FIELD_W   = 16;
	localparam int CNT_W     = 5;
	localparam int PROB_W    = 8;
	localparam int PULSE_W   = 16;
	localparam int RNG_W     = 32;
	localparam int SUM_W     = 12;
	localparam int DRAW_W    = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 64;
	localparam int MAX_CHANNELS = 16;

	localparam logic [CFG_IDX_W-1:0] REG_SINGLE_MODE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PROB_LOW     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PROB_HIGH    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TRIG_TICKS   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RNG_SEED     = 3'd5;

	localparam logic [CFG_DATA_W-1:0] PROB_RESET = 64'h8080808080808080;
	localparam logic [CNT_W-1:0]      CHANNEL_COUNT_RESET = 5'd8;
	localparam logic [PULSE_W-1:0]    TRIG_TICKS_RESET = 16'd48;
	localparam logic [RNG_W-1:0]      RNG_SEED_RESET = 32'd1;

	typedef struct packed {
		logic [FIELD_W-1:0] clock_levels;
		logic               reset_level;
		logic               clock_is_poly;
		logic [CNT_W-1:0]   clock_channels;
	} sample_t;

	typedef struct packed {
		logic [FIELD_W-1:0] gate_bits;
		logic [FIELD_W-1:0] trig_bits;
		logic [FIELD_W-1:0] clock_bits;
		logic [CNT_W-1:0]   active_channels;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUM,
		ST_MUL,
		ST_PASS,
		ST_OUT
	} state_t;

	// xorshift32 step
	function automatic logic [RNG_W-1:0] rng_step(input logic [RNG_W-1:0] x);
		logic [RNG_W-1:0] y;
		y = x ^ (x << 13);
		y = y ^ (y >> 17);
		y = y ^ (y << 5);
		return y;
	endfunction

	function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] c,
			input logic [CNT_W-1:0] max_c);
		logic [CNT_W-1:0] r;
		if (c == '0) begin
			r = CNT_W'(1);
		end else if (c > max_c) begin
			r = max_c;
		end else begin
			r = c;
		end
		return r;
	endfunction

	function automatic logic [RNG_W-1:0] seed_value(input logic [RNG_W-1:0] s);
		return (s == '0) ? RNG_W'(1) : s;
	endfunction

endpackage

// ===== rtl/core/pcgr_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module pcgr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/core/probabilistic_clock_gate_router.sv =====
// top level of the probabilistic clock gate router (multichannel bernoulli gate)
// depends on pcgr_pkg and pcgr_ram (pulse counter memory)
//
//   port group   direction  handshake                 payload
//   sample       in         sample_valid/sample_stall pcgr_pkg::sample_t
//   result       out        result_valid/result_stall pcgr_pkg::result_t
//   cfg          in         cfg_we                    cfg_index, cfg_data
//
// an item passes through accept, one pass over the pulse counter memory at one
// channel a cycle, each using its registered counter read, and the result load.
// single mode with a channel 0 edge and no reset edge first sums the
// probabilities of the n channels and then does the scaling multiply.
// reset clears control state at once; counters read as zero until first written.
// a result waiting on result_stall does not block the next item's pass.
module probabilistic_clock_gate_router #(
	parameter int NUM_CHANNELS = 16,
	parameter int PROB_BITS    = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [pcgr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pcgr_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                sample_valid,
	output logic                                sample_stall,
	input  pcgr_pkg::sample_t                   sample,
	output logic                                result_valid,
	input  logic                                result_stall,
	output pcgr_pkg::result_t                   result
);

	localparam int CW = $clog2(NUM_CHANNELS);
	localparam int IW = $clog2(NUM_CHANNELS + 1);
	localparam int TW = PROB_BITS + 8;
	localparam logic [pcgr_pkg::CNT_W-1:0] N_MAX = pcgr_pkg::CNT_W'(NUM_CHANNELS);
	localparam logic [IW-1:0] I_END = IW'(NUM_CHANNELS);
	localparam logic [CW-1:0] C_LAST = CW'(NUM_CHANNELS - 1);

	// configuration
	logic                               single_mode_q;
	logic [pcgr_pkg::CNT_W-1:0]         channel_count_q;
	logic [pcgr_pkg::CFG_DATA_W-1:0]    prob_low_q;
	logic [pcgr_pkg::CFG_DATA_W-1:0]    prob_high_q;
	logic [pcgr_pkg::PULSE_W-1:0]       trig_ticks_q;

	// block state
	pcgr_pkg::state_t                   state_q, state_d;
	logic [NUM_CHANNELS-1:0]            clk_prev_q;
	logic                               rst_prev_q;
	logic [NUM_CHANNELS-1:0]            outcome_q;
	logic [NUM_CHANNELS-1:0]            pulse_vld_q;
	logic [pcgr_pkg::RNG_W-1:0]         rng_q;

	// per item
	logic                               single_q;
	logic                               poly_q;
	logic                               rst_edge_q;
	logic [NUM_CHANNELS-1:0]            edges_q;
	logic [pcgr_pkg::CNT_W-1:0]         n_q;
	logic [IW-1:0]                      idx_q;
	logic [pcgr_pkg::SUM_W-1:0]         sum_q;
	logic [pcgr_pkg::SUM_W-1:0]         r_q;
	logic [pcgr_pkg::SUM_W-1:0]         lo_q;
	logic [NUM_CHANNELS-1:0]            trig_acc_q;
	logic [NUM_CHANNELS-1:0]            clk_acc_q;
	logic                               rd_vld_s1;
	logic [CW-1:0]                      rd_idx_s1;

	logic                               result_valid_q;
	pcgr_pkg::result_t                  result_q;

	// ram ports
	logic                               ram_we;
	logic [CW-1:0]                      ram_raddr;
	logic [pcgr_pkg::PULSE_W-1:0]       ram_wdata;
	logic [pcgr_pkg::PULSE_W-1:0]       ram_rdata;

	// combinational
	logic                               accept;
	logic                               out_free;
	logic [pcgr_pkg::PROB_W-1:0]        prob_arr [pcgr_pkg::MAX_CHANNELS];
	logic [pcgr_pkg::RNG_W-1:0]         rng_nx;
	logic [pcgr_pkg::CNT_W-1:0]         n_new;
	logic [NUM_CHANNELS-1:0]            low_mask;
	logic [NUM_CHANNELS-1:0]            sampled;
	logic [NUM_CHANNELS-1:0]            levels;
	logic                               rst_edge_new;
	logic [pcgr_pkg::PROB_W-1:0]        sum_prob;
	logic [27:0]                        mul_prod;
	logic [CW-1:0]                      ch;
	logic [CW-1:0]                      ch_j;
	logic [CW-1:0]                      ch_k;
	logic                               ch_active;
	logic [pcgr_pkg::PULSE_W-1:0]       cur_cnt;
	logic [pcgr_pkg::PULSE_W-1:0]       new_cnt;
	logic [pcgr_pkg::PROB_W-1:0]        ch_prob;
	logic [TW-1:0]                      th_wide;
	logic [PROB_BITS-1:0]               rv;
	logic [pcgr_pkg::SUM_W:0]           hi_sum;
	logic                               do_set;
	logic                               set_val;
	logic                               draw;
	logic                               new_o;
	logic                               sum_last;
	logic                               pass_last;

	assign accept       = (state_q == pcgr_pkg::ST_IDLE) && sample_valid;
	assign sample_stall = (state_q != pcgr_pkg::ST_IDLE);
	assign out_free     = !result_valid_q || !result_stall;
	assign rng_nx       = pcgr_pkg::rng_step(rng_q);

	always_comb begin
		for (int i = 0; i < pcgr_pkg::MAX_CHANNELS / 2; i++) begin
			prob_arr[i]     = prob_low_q[i*8 +: 8];
			prob_arr[i + 8] = prob_high_q[i*8 +: 8];
		end
	end

	// item intake: channel count, sampled clocks, edges
	always_comb begin
		if (single_mode_q && sample.clock_is_poly) begin
			n_new = pcgr_pkg::clamp_count(sample.clock_channels, N_MAX);
		end else begin
			n_new = pcgr_pkg::clamp_count(channel_count_q, N_MAX);
		end
		for (int i = 0; i < NUM_CHANNELS; i++) begin
			low_mask[i] = (pcgr_pkg::CNT_W'(i) < n_new);
		end
		if (!single_mode_q && sample.clock_is_poly) begin
			sampled = low_mask;
		end else begin
			sampled = NUM_CHANNELS'(1);
		end
		levels       = sample.clock_levels[NUM_CHANNELS-1:0];
		rst_edge_new = sample.reset_level && !rst_prev_q;
	end

	// single mode prefix work
	always_comb begin
		sum_prob = prob_arr[4'(idx_q[CW-1:0])];
		sum_last = (pcgr_pkg::CNT_W'(idx_q) + pcgr_pkg::CNT_W'(1)) == n_q;
		mul_prod = 28'(rng_nx[pcgr_pkg::RNG_W-1 -: pcgr_pkg::DRAW_W]) * 28'(sum_q);
	end

	// one channel of the pass, using the counter read in the previous cycle
	always_comb begin
		ch        = rd_idx_s1;
		ch_active = (pcgr_pkg::CNT_W'(ch) < n_q);
		cur_cnt   = pulse_vld_q[ch] ? ram_rdata : '0;
		ch_prob   = prob_arr[4'(ch)];
		ch_j      = poly_q ? ch : '0;
		ch_k      = (single_q || !poly_q) ? '0 : ch;
		th_wide   = {ch_prob, {PROB_BITS{1'b0}}} >> 8;
		rv        = rng_nx[pcgr_pkg::RNG_W-1 -: PROB_BITS];
		hi_sum    = {1'b0, lo_q} + (pcgr_pkg::SUM_W + 1)'(ch_prob);
		do_set    = 1'b0;
		set_val   = 1'b0;
		draw      = 1'b0;
		if (rst_edge_q) begin
			do_set = 1'b0;
		end else if (single_q) begin
			do_set  = edges_q[0] && ch_active;
			set_val = (r_q >= lo_q) && ({1'b0, r_q} < hi_sum);
		end else begin
			do_set  = ch_active;
			draw    = ch_active && edges_q[ch_j];
			set_val = draw && (TW'(rv) < th_wide);
		end
		new_o = do_set ? set_val : outcome_q[ch];
		if (do_set && set_val && !outcome_q[ch] && (cur_cnt < trig_ticks_q)) begin
			new_cnt = trig_ticks_q;
		end else begin
			new_cnt = cur_cnt;
		end
		ram_wdata = (new_cnt != '0) ? new_cnt - pcgr_pkg::PULSE_W'(1) : new_cnt;
		ram_we    = (state_q == pcgr_pkg::ST_PASS) && rd_vld_s1;
		ram_raddr = idx_q[CW-1:0];
		pass_last = rd_vld_s1 && (ch == C_LAST);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pcgr_pkg::ST_IDLE: begin
				if (accept) begin
					if (!rst_edge_new && single_mode_q && levels[0] && !clk_prev_q[0]) begin
						state_d = pcgr_pkg::ST_SUM;
					end else begin
						state_d = pcgr_pkg::ST_PASS;
					end
				end
			end
			pcgr_pkg::ST_SUM: begin
				if (sum_last) begin
					state_d = pcgr_pkg::ST_MUL;
				end
			end
			pcgr_pkg::ST_MUL: begin
				state_d = pcgr_pkg::ST_PASS;
			end
			pcgr_pkg::ST_PASS: begin
				if (pass_last) begin
					state_d = pcgr_pkg::ST_OUT;
				end
			end
			pcgr_pkg::ST_OUT: begin
				if (out_free) begin
					state_d = pcgr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pcgr_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pcgr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			single_mode_q   <= 1'b0;
			channel_count_q <= pcgr_pkg::CHANNEL_COUNT_RESET;
			prob_low_q      <= pcgr_pkg::PROB_RESET;
			prob_high_q     <= pcgr_pkg::PROB_RESET;
			trig_ticks_q    <= pcgr_pkg::TRIG_TICKS_RESET;
			rng_q           <= pcgr_pkg::RNG_SEED_RESET;
			clk_prev_q      <= '0;
			rst_prev_q      <= 1'b0;
			outcome_q       <= '0;
			pulse_vld_q     <= '0;
			rd_vld_s1       <= 1'b0;
			result_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					pcgr_pkg::REG_SINGLE_MODE:   single_mode_q   <= cfg_data[0];
					pcgr_pkg::REG_CHANNEL_COUNT: channel_count_q <= cfg_data[pcgr_pkg::CNT_W-1:0];
					pcgr_pkg::REG_PROB_LOW:      prob_low_q      <= cfg_data;
					pcgr_pkg::REG_PROB_HIGH:     prob_high_q     <= cfg_data;
					pcgr_pkg::REG_TRIG_TICKS:    trig_ticks_q    <= cfg_data[pcgr_pkg::PULSE_W-1:0];
					pcgr_pkg::REG_RNG_SEED: begin
						rng_q <= pcgr_pkg::seed_value(cfg_data[pcgr_pkg::RNG_W-1:0]);
					end
					default: begin
					end
				endcase
			end

			// a new result may replace the one taken in the same cycle
			priority if ((state_q == pcgr_pkg::ST_OUT) && out_free) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end

			unique case (state_q)
				pcgr_pkg::ST_IDLE: begin
					if (accept) begin
						clk_prev_q <= (clk_prev_q & ~sampled) | (levels & sampled);
						rst_prev_q <= sample.reset_level;
						if (rst_edge_new) begin
							outcome_q   <= '0;
							pulse_vld_q <= '0;
						end
					end
				end
				pcgr_pkg::ST_MUL: begin
					rng_q <= rng_nx;
				end
				pcgr_pkg::ST_PASS: begin
					rd_vld_s1 <= (idx_q != I_END);
					if (rd_vld_s1) begin
						outcome_q[ch]   <= new_o;
						pulse_vld_q[ch] <= 1'b1;
						if (draw) begin
							rng_q <= rng_nx;
						end
					end
				end
				pcgr_pkg::ST_OUT: begin
					rd_vld_s1 <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	// item payload registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			pcgr_pkg::ST_IDLE: begin
				if (accept) begin
					single_q   <= single_mode_q;
					poly_q     <= sample.clock_is_poly;
					rst_edge_q <= rst_edge_new;
					edges_q    <= levels & ~clk_prev_q & sampled;
					n_q        <= n_new;
					idx_q      <= '0;
					sum_q      <= '0;
					lo_q       <= '0;
					r_q        <= '0;
				end
			end
			pcgr_pkg::ST_SUM: begin
				sum_q <= sum_q + pcgr_pkg::SUM_W'(sum_prob);
				idx_q <= sum_last ? '0 : idx_q + IW'(1);
			end
			pcgr_pkg::ST_MUL: begin
				r_q <= mul_prod[27:16];
			end
			pcgr_pkg::ST_PASS: begin
				if (idx_q != I_END) begin
					idx_q <= idx_q + IW'(1);
				end
				rd_idx_s1 <= ram_raddr;
				if (rd_vld_s1) begin
					trig_acc_q[ch] <= (new_cnt != '0);
					clk_acc_q[ch]  <= new_o && clk_prev_q[ch_k];
					if (single_q && ch_active) begin
						lo_q <= hi_sum[pcgr_pkg::SUM_W-1:0];
					end
				end
			end
			pcgr_pkg::ST_OUT: begin
				if (out_free) begin
					result_q.gate_bits       <= pcgr_pkg::FIELD_W'(outcome_q);
					result_q.trig_bits       <= pcgr_pkg::FIELD_W'(trig_acc_q);
					result_q.clock_bits      <= pcgr_pkg::FIELD_W'(clk_acc_q);
					result_q.active_channels <= n_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	pcgr_ram #(
		.WIDTH(pcgr_pkg::PULSE_W),
		.DEPTH(NUM_CHANNELS)
	) u_pulse_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ch),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// counter memory is written only while a channel is being processed
	assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == pcgr_pkg::ST_PASS) && rd_vld_s1)
	else $error("pulse counter written outside the channel pass");

	// a reset edge clears every outcome before the pass
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && rst_edge_new) |=> (outcome_q == '0) && (pulse_vld_q == '0))
	else $error("reset edge did not clear outcomes and counters");

	// the generator never locks at zero
	assert property (@(posedge clk) disable iff (!arst_n)
		rng_q != '0)
	else $error("random generator reached zero");

	// a new result appears only at the end of an item
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> ($past(state_q) == pcgr_pkg::ST_OUT))
	else $error("result raised outside the result load");

	// no new item is taken while the channel pass runs
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pcgr_pkg::ST_PASS) |-> sample_stall)
	else $error("item accepted during the channel pass");

endmodule

// ===== dv/gate_check_pkg.sv =====
// scoreboard class for the probabilistic clock gate router testbench
// tracks register settings and gate state, predicts one result per sample tick
// depends on pcgr_pkg for the payload types and register indexes
package gate_check_pkg;
	import pcgr_pkg::*;

	localparam int GATE_CHANNELS  = 16;
	localparam int GATE_PROB_BITS = 8;

	class gate_scoreboard;
		// register copies
		bit                   single_mode;
		bit [CNT_W-1:0]       channel_count;
		bit [CFG_DATA_W-1:0]  prob_lo;
		bit [CFG_DATA_W-1:0]  prob_hi;
		bit [PULSE_W-1:0]     trig_ticks;
		bit [RNG_W-1:0]       rng_seed;

		// gate state
		bit [FIELD_W-1:0]     clock_prev;
		bit                   reset_prev;
		bit [FIELD_W-1:0]     outcome;
		bit [PULSE_W-1:0]     pulse_left [GATE_CHANNELS];
		bit [RNG_W-1:0]       rng_word;

		result_t              pending_results [$];
		int                   mismatches;
		int                   compared;
		int                   ticks_seen;
		int                   reg_writes;

		function new();
			single_mode   = 1'b0;
			channel_count = CHANNEL_COUNT_RESET;
			prob_lo       = PROB_RESET;
			prob_hi       = PROB_RESET;
			trig_ticks    = TRIG_TICKS_RESET;
			rng_seed      = RNG_SEED_RESET;
			clock_prev    = '0;
			reset_prev    = 1'b0;
			outcome       = '0;
			foreach (pulse_left[i]) pulse_left[i] = '0;
			rng_word      = RNG_SEED_RESET;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			reg_writes++;
			case (idx)
				REG_SINGLE_MODE: begin
					single_mode = data[0];
				end
				REG_CHANNEL_COUNT: begin
					channel_count = data[CNT_W-1:0];
				end
				REG_PROB_LOW: begin
					prob_lo = data;
				end
				REG_PROB_HIGH: begin
					prob_hi = data;
				end
				REG_TRIG_TICKS: begin
					trig_ticks = data[PULSE_W-1:0];
				end
				REG_RNG_SEED: begin
					// the generator reloads at once, zero is replaced by one
					rng_seed = data[RNG_W-1:0];
					rng_word = (rng_seed == '0) ? 32'd1 : rng_seed;
				end
				default: begin
				end
			endcase
		endfunction

		function int pending();
			return pending_results.size();
		endfunction

		function bit [7:0] channel_prob(int i);
			return (i < 8) ? prob_lo[i*8 +: 8] : prob_hi[(i-8)*8 +: 8];
		endfunction

		function bit [RNG_W-1:0] next_draw_word();
			bit [RNG_W-1:0] x;
			x = rng_word;
			x ^= x << 13;
			x ^= x >> 17;
			x ^= x << 5;
			rng_word = x;
			return x;
		endfunction

		function bit [CNT_W-1:0] limit_count(bit [CNT_W-1:0] c);
			if (c == '0) return 5'd1;
			if (c > GATE_CHANNELS) return 5'(GATE_CHANNELS);
			return c;
		endfunction

		function void drive_outcome(int i, bit v);
			bit was;
			was = outcome[i];
			outcome[i] = v;
			if (v && !was && pulse_left[i] < trig_ticks) pulse_left[i] = trig_ticks;
		endfunction

		function void note_sample(sample_t s);
			bit [FIELD_W-1:0] levels;
			bit [FIELD_W-1:0] sampled;
			bit [FIELD_W-1:0] edges;
			bit [FIELD_W-1:0] trig;
			bit [FIELD_W-1:0] clk_out;
			bit               single;
			bit               poly;
			bit               rst_edge;
			bit [CNT_W-1:0]   n;
			bit [SUM_W-1:0]   prob_sum;
			bit [SUM_W-1:0]   lo;
			bit [SUM_W-1:0]   hi;
			bit [31:0]        draw;
			bit [31:0]        thresh;
			result_t          r;

			ticks_seen++;
			levels = s.clock_levels;
			single = single_mode;
			poly   = s.clock_is_poly;
			n = limit_count(channel_count);
			if (single && poly) n = limit_count(s.clock_channels);

			// only multi poly mode looks at clocks other than channel 0
			sampled = (!single && poly) ? 16'((32'd1 << n) - 32'd1) : 16'd1;
			edges = levels & ~clock_prev & sampled;
			clock_prev = (clock_prev & ~sampled) | (levels & sampled);

			rst_edge = s.reset_level && !reset_prev;
			reset_prev = s.reset_level;

			if (rst_edge) begin
				outcome = '0;
				foreach (pulse_left[i]) pulse_left[i] = '0;
			end else if (single) begin
				if (edges[0]) begin
					prob_sum = '0;
					for (int i = 0; i < n; i++) prob_sum += channel_prob(i);
					draw = ((next_draw_word() >> 16) * prob_sum) >> 16;
					lo = '0;
					// weighted pick, an all-zero sum picks nobody
					for (int i = 0; i < n; i++) begin
						hi = lo + channel_prob(i);
						drive_outcome(i, draw >= lo && draw < hi);
						lo = hi;
					end
				end
			end else begin
				for (int i = 0; i < n; i++) begin
					if (edges[poly ? i : 0]) begin
						draw = next_draw_word() >> (32 - GATE_PROB_BITS);
						thresh = (32'(channel_prob(i)) << GATE_PROB_BITS) >> 8;
						drive_outcome(i, draw < thresh);
					end else begin
						drive_outcome(i, 1'b0);
					end
				end
			end

			trig = '0;
			clk_out = '0;
			for (int i = 0; i < GATE_CHANNELS; i++) begin
				// trigger bit is taken before the count goes down
				if (pulse_left[i] != '0) begin
					trig[i] = 1'b1;
					pulse_left[i]--;
				end
				if (outcome[i] && clock_prev[(single || !poly) ? 0 : i]) clk_out[i] = 1'b1;
			end

			r.gate_bits       = outcome;
			r.trig_bits       = trig;
			r.clock_bits      = clk_out;
			r.active_channels = n;
			pending_results.push_back(r);
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (pending_results.size() == 0) begin
				$error("result with no sample tick waiting: %h", got);
				mismatches++;
				return;
			end
			want = pending_results.pop_front();
			compared++;
			if (got.gate_bits !== want.gate_bits) begin
				$error("gate_bits: expected %h, actual %h", want.gate_bits, got.gate_bits);
				mismatches++;
			end
			if (got.trig_bits !== want.trig_bits) begin
				$error("trig_bits: expected %h, actual %h", want.trig_bits, got.trig_bits);
				mismatches++;
			end
			if (got.clock_bits !== want.clock_bits) begin
				$error("clock_bits: expected %h, actual %h", want.clock_bits, got.clock_bits);
				mismatches++;
			end
			if (got.active_channels !== want.active_channels) begin
				$error("active_channels: expected %0d, actual %0d",
					want.active_channels, got.active_channels);
				mismatches++;
			end
		endfunction
	endclass

endpackage

// ===== dv/testbench.sv =====
// top of the probabilistic clock gate router testbench: clock, reset, drivers
// runs directed ticks then randomized register settings with random stalls
// depends on pcgr_pkg, gate_check_pkg and the probabilistic_clock_gate_router rtl
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import pcgr_pkg::*;
	import gate_check_pkg::*;

	// slowest tick: channel pass plus single mode sum and multiply
	localparam int TICK_CYCLES     = 2 * MAX_CHANNELS + 4;
	localparam int WATCHDOG_LIMIT  = 40 * TICK_CYCLES;
	localparam int RANDOM_PHASES   = 8;
	localparam int ITEMS_PER_PHASE = 60;

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  cfg_we       = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index    = '0;
	logic [CFG_DATA_W-1:0] cfg_data     = '0;
	logic                  sample_valid = 1'b0;
	logic                  sample_stall;
	sample_t               sample       = '0;
	logic                  result_valid;
	logic                  result_stall = 1'b0;
	result_t               result;

	gate_scoreboard sb;
	bit             throttle_on = 1'b1;
	int             stall_left  = 0;
	int             idle_cycles = 0;

	probabilistic_clock_gate_router dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// result side: check accepted items, stall in random bursts
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) sb.check_result(result);
		if (stall_left > 0) begin
			stall_left--;
			result_stall <= 1'b1;
		end else if (throttle_on && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 11);
			result_stall <= 1'b1;
		end else begin
			result_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (sample_valid && !sample_stall) || (result_valid && !result_stall)
				|| cfg_we) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no handshake for %0d cycles", idle_cycles);
				$display("testbench NOT OK");
				$finish;
			end
		end
	end

	function automatic sample_t make_sample(logic [FIELD_W-1:0] levels, logic rst,
			logic poly, logic [CNT_W-1:0] cch);
		sample_t s;
		s.clock_levels   = levels;
		s.reset_level    = rst;
		s.clock_is_poly  = poly;
		s.clock_channels = cch;
		return s;
	endfunction

	function automatic logic [CFG_DATA_W-1:0] random_prob_word();
		logic [CFG_DATA_W-1:0] w;
		for (int b = 0; b < 8; b++) begin
			case ($urandom_range(0, 3))
				0: w[b*8 +: 8] = 8'h00;
				1: w[b*8 +: 8] = 8'hFF;
				default: w[b*8 +: 8] = 8'($urandom_range(0, 255));
			endcase
		end
		return w;
	endfunction

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		sb.write_reg(idx, data);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// drop valid and hold off until every expected result is back
	task automatic wait_drained();
		sample_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	task automatic send_sample(sample_t s);
		int gap;
		gap = (throttle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_valid <= 1'b1;
		sample       <= s;
		do @(posedge clk); while (!(sample_valid && !sample_stall));
		sb.note_sample(s);
	endtask

	task automatic random_settings(int phase);
		logic [CFG_DATA_W-1:0] ticks;
		case ($urandom_range(0, 7))
			0: ticks = '0;
			1: ticks = 64'hFFFF;
			default: ticks = 64'($urandom_range(1, 64));
		endcase
		write_reg(REG_SINGLE_MODE, 64'(phase % 2));
		write_reg(REG_CHANNEL_COUNT, 64'(($urandom_range(0, 3) == 0) ?
			$urandom_range(0, 31) : $urandom_range(1, 16)));
		write_reg(REG_PROB_LOW, random_prob_word());
		write_reg(REG_PROB_HIGH, random_prob_word());
		write_reg(REG_TRIG_TICKS, ticks);
		write_reg(REG_RNG_SEED, 64'($urandom()));
	endtask

	initial begin
		sample_t s;
		sb = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: multi mode, eight channels
		send_sample(make_sample(16'h0000, 1'b0, 1'b0, 5'd0));
		send_sample(make_sample(16'hFFFF, 1'b0, 1'b0, 5'd8));
		send_sample(make_sample(16'h0000, 1'b0, 1'b0, 5'd8));
		send_sample(make_sample(16'hFFFF, 1'b0, 1'b1, 5'd16));
		send_sample(make_sample(16'h0000, 1'b0, 1'b1, 5'd16));
		send_sample(make_sample(16'hFFFF, 1'b1, 1'b1, 5'd31));
		send_sample(make_sample(16'hFFFF, 1'b1, 1'b0, 5'd0));
		send_sample(make_sample(16'h0000, 1'b0, 1'b0, 5'd1));
		send_sample(make_sample(16'hAAAA, 1'b0, 1'b1, 5'd5));
		send_sample(make_sample(16'h5555, 1'b0, 1'b1, 5'd5));

		// single mode, zero probabilities, zero pulse length, zero seed
		wait_drained();
		write_reg(REG_SINGLE_MODE, 64'd1);
		write_reg(REG_CHANNEL_COUNT, 64'd0);
		write_reg(REG_PROB_LOW, 64'd0);
		write_reg(REG_PROB_HIGH, 64'd0);
		write_reg(REG_TRIG_TICKS, 64'd0);
		write_reg(REG_RNG_SEED, 64'd0);
		send_sample(make_sample(16'h0001, 1'b0, 1'b0, 5'd3));
		send_sample(make_sample(16'h0000, 1'b0, 1'b0, 5'd3));
		send_sample(make_sample(16'hFFFF, 1'b0, 1'b1, 5'd0));
		send_sample(make_sample(16'h0000, 1'b0, 1'b1, 5'd0));

		// single mode, full probabilities, longest pulse, oversized count
		wait_drained();
		write_reg(REG_PROB_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
		write_reg(REG_PROB_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
		write_reg(REG_CHANNEL_COUNT, 64'd31);
		write_reg(REG_TRIG_TICKS, 64'hFFFF);
		write_reg(REG_RNG_SEED, 64'hFFFF_FFFF);
		send_sample(make_sample(16'h0001, 1'b0, 1'b1, 5'd31));
		send_sample(make_sample(16'h0000, 1'b0, 1'b1, 5'd31));
		send_sample(make_sample(16'h0001, 1'b0, 1'b1, 5'd16));
		send_sample(make_sample(16'h0000, 1'b0, 1'b0, 5'd2));
		send_sample(make_sample(16'h0001, 1'b0, 1'b0, 5'd2));
		send_sample(make_sample(16'hFFFE, 1'b0, 1'b0, 5'd9));

		// back to multi mode with all channels
		wait_drained();
		write_reg(REG_SINGLE_MODE, 64'd0);
		write_reg(REG_CHANNEL_COUNT, 64'd16);
		write_reg(REG_RNG_SEED, 64'h1234_5678);
		send_sample(make_sample(16'hFFFF, 1'b0, 1'b1, 5'd16));
		send_sample(make_sample(16'h0000, 1'b0, 1'b1, 5'd16));
		send_sample(make_sample(16'hFFFF, 1'b0, 1'b0, 5'd16));
		send_sample(make_sample(16'h0000, 1'b0, 1'b0, 5'd0));
		send_sample(make_sample(16'hFFFF, 1'b1, 1'b0, 5'd16));

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			throttle_on = (phase != 3) && (phase != RANDOM_PHASES - 1);
			wait_drained();
			random_settings(phase);
			for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
				s.clock_levels   = 16'($urandom());
				s.reset_level    = ($urandom_range(0, 19) == 0);
				s.clock_is_poly  = 1'($urandom_range(0, 1));
				s.clock_channels = ($urandom_range(0, 3) == 0) ?
					5'($urandom_range(0, 31)) : 5'($urandom_range(1, 16));
				send_sample(s);
				if ($urandom_range(0, 49) == 0) wait_drained();
			end
		end

		wait_drained();
		repeat (2 * TICK_CYCLES) @(posedge clk);
		$display("%0d sample ticks in both gate modes, %0d register writes, %0d results compared",
			sb.ticks_seen, sb.reg_writes, sb.compared);
		if (sb.mismatches == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end

endmodule
